// ----- design/kts_pkg.sv -----
// Package for the keyframe track sampler: opcodes, status codes, command and status structs.
// No dependencies; used by kts_ctrl, kts_dpath and keyframe_track_sampler.
package kts_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int TDATA_IN_W  = 136;
    localparam int TDATA_OUT_W = 104;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat, reset scan index
        logic scan_rd;   // read entry at scan index
        logic scan_adv;  // compare read time, advance index
        logic ins_wr;    // write input key at scan index (overwrite or new slot)
        logic sh_init;   // start shift at key_count
        logic sh_rd;     // read entry at shift index - 1
        logic sh_wr;     // write read entry at shift index, decrement
        logic cnt_inc;
        logic cnt_clr;
        logic lo_rd;     // read lower key
        logic lo_cap;    // capture lower key (the upper key is read by scan_rd)
        logic hi_cap;    // capture upper key, start division
        logic div_step;
        logic mul_step;  // axis multiply / accumulate steps
        logic res_edge;  // result = entry at read address (edge key)
        logic res_zero;
        logic res_lerp;
        logic [1:0] res_status;
        logic res_load;
    } kts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       empty;
        logic       full;
        logic       scan_end;   // scan index reached key_count
        logic       time_lt;    // read time < request
        logic       time_le;    // read time <= request
        logic       time_eq;
        logic       sh_done;    // shift index reached scan index
        logic       scan_zero;
        logic       div_done;
        logic       mul_done;
        logic       out_busy;   // result register still full
    } kts_stat_t;

endpackage

// ----- design/keyframe_track_sampler.sv -----
// Top level of the keyframe track sampler: stream ports, controller and datapath.
// Depends on kts_pkg, kts_ctrl and kts_dpath.
//
// A time-sorted table of up to MAX_KEYS translation keys, all values signed Q16.16.
// Each input beat gives exactly one result beat. Insert (opcode 0) scans the table
// one entry at a time (read, wait, compare), then overwrites, appends, or shifts the
// tail up one entry at a time (read, wait, write); scan and shift together cover the
// table once. Sample (opcode 1) scans the same way; outside the keys it returns the
// edge key, else it reads both neighbors and runs a 48-step restoring divider for the
// fraction and a shared multiplier over the three axes. Clear (opcode 2) is handled
// in the idle state. The registered read of the key memory sets the scan and shift
// pace. One beat is processed at a time; the result register holds a finished beat.
module keyframe_track_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: opcode[1:0], time_req[33:2], in_x[65:34], in_y[97:66], in_z[129:98], zero pad
    input  logic [kts_pkg::TDATA_IN_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: out_x[31:0], out_y[63:32], out_z[95:64], status[97:96], zero pad
    output logic [kts_pkg::TDATA_OUT_W-1:0]   m_tdata
);
    import kts_pkg::*;

    kts_cmd_t  cmd;
    kts_stat_t stat;
    logic [31:0] rx, ry, rz;
    logic [1:0]  rs;

    kts_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tdata[1:0]),
        .cmd, .stat
    );

    kts_dpath #(.MAX_KEYS(MAX_KEYS)) u_dpath (
        .aclk, .aresetn, .cmd, .stat,
        .in_time    (s_tdata[33:2]),
        .in_x       (s_tdata[65:34]),
        .in_y       (s_tdata[97:66]),
        .in_z       (s_tdata[129:98]),
        .res_x      (rx),
        .res_y      (ry),
        .res_z      (rz),
        .res_status (rs),
        .res_valid  (m_tvalid),
        .res_taken  (m_tready)
    );

    assign m_tdata = {6'd0, rs, rz, ry, rx};
endmodule

// ----- design/kts_dpath.sv -----
// Datapath of the keyframe track sampler: key memory, scan/shift index, divider, lerp.
// Depends on kts_pkg; driven by kts_ctrl.
module kts_dpath #(
    parameter int MAX_KEYS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kts_pkg::kts_cmd_t   cmd,
    output kts_pkg::kts_stat_t  stat,
    input  logic [31:0]         in_time,
    input  logic [31:0]         in_x,
    input  logic [31:0]         in_y,
    input  logic [31:0]         in_z,
    output logic [31:0]         res_x,
    output logic [31:0]         res_y,
    output logic [31:0]         res_z,
    output logic [1:0]          res_status,
    output logic                res_valid,
    input  logic                res_taken
);
    import kts_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [127:0] mem [MAX_KEYS];   // {z, y, x, time}
    logic [127:0] rd_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          we;
    logic [127:0]  wdata;

    logic [CW-1:0] cnt_reg, idx_reg, sh_reg;
    logic [31:0]   t_reg, x_reg, y_reg, z_reg;
    logic [127:0]  lo_reg, hi_reg;
    logic [31:0]   span_reg;
    logic [48:0]   rem_reg;
    logic [47:0]   dt_reg;   // shifting dividend
    logic [15:0]   frac_reg;
    logic [5:0]    dcnt_reg;
    logic [1:0]    axis_reg;
    logic [1:0]    mphase_reg;
    logic signed [32:0] diff_reg;
    logic signed [50:0] prod_reg;
    logic [31:0]   ox_reg, oy_reg, oz_reg;
    logic [31:0]   rx_reg, ry_reg, rz_reg;
    logic [1:0]    rs_reg;
    logic          rv_reg;

    // memory port selection
    always_comb begin
        raddr = idx_reg[AW-1:0];
        if (cmd.sh_rd)
            raddr = AW'(sh_reg - CW'(1));
        else if (cmd.lo_rd)
            raddr = AW'(idx_reg - CW'(1));
        else if (cmd.res_edge)
            raddr = AW'(idx_reg);
        we    = cmd.ins_wr | cmd.sh_wr;
        waddr = cmd.sh_wr ? sh_reg[AW-1:0] : idx_reg[AW-1:0];
        wdata = cmd.sh_wr ? rd_reg : {z_reg, y_reg, x_reg, t_reg};
    end

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    logic signed [31:0] rd_t;
    assign rd_t = rd_reg[31:0];

    always_comb begin
        stat.empty     = (cnt_reg == '0);
        stat.full      = (cnt_reg == CW'(MAX_KEYS));
        stat.scan_end  = (idx_reg == cnt_reg);
        stat.time_lt   = rd_t <  $signed(t_reg);
        stat.time_le   = rd_t <= $signed(t_reg);
        stat.time_eq   = rd_t == $signed(t_reg);
        stat.sh_done   = (sh_reg == idx_reg);
        stat.scan_zero = (idx_reg == '0);
        stat.div_done  = (dcnt_reg == 6'd48);
        stat.mul_done  = (axis_reg == 2'd3);
        stat.out_busy  = rv_reg;
    end

    // restoring division: (dt << 16) / span, one quotient bit a cycle
    logic [48:0] rem_sh;
    logic [48:0] rem_sub;
    assign rem_sh  = {rem_reg[47:0], dt_reg[47]};
    assign rem_sub = rem_sh - {17'd0, span_reg};

    // axis values for lerp
    logic [31:0] v0, v1;
    always_comb begin
        case (axis_reg)
            2'd0:    begin v0 = lo_reg[63:32];  v1 = hi_reg[63:32];  end
            2'd1:    begin v0 = lo_reg[95:64];  v1 = hi_reg[95:64];  end
            default: begin v0 = lo_reg[127:96]; v1 = hi_reg[127:96]; end
        endcase
    end
    logic signed [32:0] lerp_sum;
    assign lerp_sum = $signed({v0[31], v0}) + 33'(prod_reg >>> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rv_reg  <= 1'b0;
        end else begin
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CW'(1);
            if (cmd.res_load)
                rv_reg <= 1'b1;
            else if (res_taken)
                rv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            t_reg   <= in_time;
            x_reg   <= in_x;
            y_reg   <= in_y;
            z_reg   <= in_z;
            idx_reg <= '0;
        end
        if (cmd.scan_adv)
            idx_reg <= idx_reg + CW'(1);
        if (cmd.sh_init)
            sh_reg <= cnt_reg;
        if (cmd.sh_wr)
            sh_reg <= sh_reg - CW'(1);
        if (cmd.lo_cap)
            lo_reg <= rd_reg;
        if (cmd.hi_cap) begin
            hi_reg   <= rd_reg;
            span_reg <= rd_reg[31:0] - lo_reg[31:0];
            dt_reg   <= {t_reg - lo_reg[31:0], 16'd0};
            rem_reg  <= '0;
            dcnt_reg <= '0;
            axis_reg <= '0;
            mphase_reg <= '0;
        end
        if (cmd.div_step) begin
            dt_reg   <= {dt_reg[46:0], 1'b0};
            dcnt_reg <= dcnt_reg + 6'd1;
            if (!rem_sub[48]) begin
                rem_reg  <= rem_sub;
                frac_reg <= {frac_reg[14:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                frac_reg <= {frac_reg[14:0], 1'b0};
            end
        end
        // per axis: diff, multiply, add
        if (cmd.mul_step) begin
            case (mphase_reg)
                2'd0: begin
                    diff_reg   <= $signed({v1[31], v1}) - $signed({v0[31], v0});
                    mphase_reg <= 2'd1;
                end
                2'd1: begin
                    prod_reg   <= diff_reg * $signed({1'b0, frac_reg});
                    mphase_reg <= 2'd2;
                end
                default: begin
                    case (axis_reg)
                        2'd0:    ox_reg <= lerp_sum[31:0];
                        2'd1:    oy_reg <= lerp_sum[31:0];
                        default: oz_reg <= lerp_sum[31:0];
                    endcase
                    axis_reg   <= axis_reg + 2'd1;
                    mphase_reg <= 2'd0;
                end
            endcase
        end
        if (cmd.res_load) begin
            rs_reg <= cmd.res_status;
            if (cmd.res_lerp) begin
                rx_reg <= ox_reg; ry_reg <= oy_reg; rz_reg <= oz_reg;
            end else if (cmd.res_zero) begin
                rx_reg <= '0; ry_reg <= '0; rz_reg <= '0;
            end else begin
                rx_reg <= rd_reg[63:32]; ry_reg <= rd_reg[95:64]; rz_reg <= rd_reg[127:96];
            end
        end
    end

    assign res_x      = rx_reg;
    assign res_y      = ry_reg;
    assign res_z      = rz_reg;
    assign res_status = rs_reg;
    assign res_valid  = rv_reg;
endmodule

// ----- design/kts_ctrl.sv -----
// Controller of the keyframe track sampler: sequences scan, shift, divide and lerp.
// Depends on kts_pkg; commands kts_dpath.
module kts_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_op,
    output kts_pkg::kts_cmd_t  cmd,
    input  kts_pkg::kts_stat_t stat
);
    import kts_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RD    = 14'b00000000000010,
        S_WAIT  = 14'b00000000000100,
        S_CMP   = 14'b00000000001000,
        S_SHRD  = 14'b00000000010000,
        S_SHWT  = 14'b00000000100000,
        S_SHWR  = 14'b00000001000000,
        S_LORD  = 14'b00000010000000,
        S_LOWT  = 14'b00000100000000,
        S_LOCAP = 14'b00001000000000,
        S_HICAP = 14'b00010000000000,
        S_DIV   = 14'b00100000000000,
        S_MUL   = 14'b01000000000000,
        S_EDGE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   op_sample_reg, op_sample_next;

    assign in_ready = (state_reg == S_IDLE) && !stat.out_busy;

    always_comb begin
        state_next     = state_reg;
        op_sample_next = op_sample_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: if (in_valid && in_ready) begin
                cmd.load       = 1'b1;
                op_sample_next = (in_op == OP_SAMPLE);
                case (in_op)
                    OP_INSERT: state_next = S_RD;
                    OP_SAMPLE: begin
                        if (stat.empty) begin
                            cmd.res_load = 1'b1; cmd.res_zero = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end else
                            state_next = S_RD;
                    end
                    OP_CLEAR: begin
                        cmd.cnt_clr = 1'b1; cmd.res_load = 1'b1; cmd.res_zero = 1'b1;
                    end
                    default: begin
                        cmd.res_load = 1'b1; cmd.res_zero = 1'b1;
                    end
                endcase
            end
            S_RD: begin
                if (stat.scan_end) begin
                    if (op_sample_reg) begin
                        // after last key: read last entry
                        cmd.lo_rd = 1'b1; state_next = S_EDGE;
                    end else if (stat.full) begin
                        cmd.res_load = 1'b1; cmd.res_zero = 1'b1;
                        cmd.res_status = ST_FULL; state_next = S_IDLE;
                    end else begin
                        cmd.ins_wr = 1'b1; cmd.cnt_inc = 1'b1;
                        cmd.res_load = 1'b1; cmd.res_zero = 1'b1; state_next = S_IDLE;
                    end
                end else begin
                    cmd.scan_rd = 1'b1; state_next = S_WAIT;
                end
            end
            S_WAIT: state_next = S_CMP;
            S_CMP: begin
                if (op_sample_reg) begin
                    if (stat.time_le) begin
                        cmd.scan_adv = 1'b1; state_next = S_RD;
                    end else if (stat.scan_zero) begin
                        cmd.res_edge = 1'b1; state_next = S_EDGE;
                    end else begin
                        cmd.lo_rd = 1'b1; state_next = S_LOWT;
                    end
                end else if (stat.time_lt) begin
                    cmd.scan_adv = 1'b1; state_next = S_RD;
                end else if (stat.time_eq) begin
                    cmd.ins_wr = 1'b1; cmd.res_load = 1'b1; cmd.res_zero = 1'b1;
                    state_next = S_IDLE;
                end else if (stat.full) begin
                    cmd.res_load = 1'b1; cmd.res_zero = 1'b1;
                    cmd.res_status = ST_FULL; state_next = S_IDLE;
                end else begin
                    cmd.sh_init = 1'b1; state_next = S_SHRD;
                end
            end
            S_SHRD: begin
                if (stat.sh_done) begin
                    cmd.ins_wr = 1'b1; cmd.cnt_inc = 1'b1;
                    cmd.res_load = 1'b1; cmd.res_zero = 1'b1; state_next = S_IDLE;
                end else begin
                    cmd.sh_rd = 1'b1; state_next = S_SHWT;
                end
            end
            // hold the read address so the entry below stays in the read register
            S_SHWT: begin
                cmd.sh_rd = 1'b1; state_next = S_SHWR;
            end
            S_SHWR: begin
                cmd.sh_wr = 1'b1; state_next = S_SHRD;
            end
            S_LOWT: begin
                cmd.lo_rd = 1'b1; state_next = S_LOCAP;
            end
            S_LOCAP: begin
                cmd.lo_cap = 1'b1; cmd.scan_rd = 1'b1; state_next = S_LORD;
            end
            S_LORD:  state_next = S_HICAP;
            S_HICAP: begin
                cmd.hi_cap = 1'b1; state_next = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done)
                    state_next = S_MUL;
                else
                    cmd.div_step = 1'b1;
            end
            S_MUL: begin
                if (stat.mul_done) begin
                    cmd.res_load = 1'b1; cmd.res_lerp = 1'b1; state_next = S_IDLE;
                end else
                    cmd.mul_step = 1'b1;
            end
            S_EDGE: begin
                cmd.res_load = 1'b1;
                cmd.res_edge = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_sample_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_sample_reg <= op_sample_next;
        end
    end
endmodule

// ----- bench/tb_keyframe_track_sampler.sv -----
// Self-checking bench for keyframe_track_sampler: drives insert/sample/clear beats,
// predicts each result with a behavioral key table, compares field by field.
// Depends on kts_pkg and the keyframe_track_sampler RTL.
`timescale 1ns / 1ps

module tb_keyframe_track_sampler;
    import kts_pkg::*;

    localparam int MAX_KEYS  = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM  = 800;
    localparam logic [1:0] OP_NONE = 2'd3;   // undefined opcode: table unchanged, zero result

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
        logic signed [31:0] t;
        logic        [1:0]  op;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pose_beat_t;

    // directed row: beat plus an optional hand-typed result
    typedef struct {
        cmd_beat_t  cmd;
        bit         typed;
        pose_beat_t res;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;  // opcode, time_req, in_x, in_y, in_z, zero pad
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;       // out_x, out_y, out_z, status, zero pad

    keyframe_track_sampler #(.MAX_KEYS(MAX_KEYS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor's own key table
    logic signed [31:0] trk_t [MAX_KEYS];
    logic signed [31:0] trk_x [MAX_KEYS];
    logic signed [31:0] trk_y [MAX_KEYS];
    logic signed [31:0] trk_z [MAX_KEYS];
    int trk_count = 0;

    pose_beat_t pose_queue[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;      // last part of the run: no idling on either side

    function automatic logic signed [31:0] lerp_axis(logic signed [31:0] v0,
                                                     logic signed [31:0] v1,
                                                     longint frac);
        longint prod;
        prod = (longint'(v1) - longint'(v0)) * frac;
        return 32'(longint'(v0) + (prod >>> 16));   // arithmetic shift floors
    endfunction

    // apply one command to the table, return the expected result
    function automatic pose_beat_t track_step(cmd_beat_t c);
        pose_beat_t r;
        int pos, hi, lo;
        longint span, dt, frac;
        r = '0;
        case (c.op)
            OP_INSERT: begin
                pos = 0;
                while (pos < trk_count && trk_t[pos] < c.t) pos++;
                if (pos < trk_count && trk_t[pos] == c.t) begin
                    trk_x[pos] = c.x; trk_y[pos] = c.y; trk_z[pos] = c.z;
                end else if (trk_count >= MAX_KEYS) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = trk_count; i > pos; i--) begin
                        trk_t[i] = trk_t[i-1]; trk_x[i] = trk_x[i-1];
                        trk_y[i] = trk_y[i-1]; trk_z[i] = trk_z[i-1];
                    end
                    trk_t[pos] = c.t; trk_x[pos] = c.x;
                    trk_y[pos] = c.y; trk_z[pos] = c.z;
                    trk_count++;
                end
            end
            OP_SAMPLE: begin
                if (trk_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    hi = 0;
                    while (hi < trk_count && trk_t[hi] <= c.t) hi++;
                    if (hi == trk_count || hi == 0) begin
                        lo = (hi == 0) ? 0 : trk_count - 1;
                        r.x = trk_x[lo]; r.y = trk_y[lo]; r.z = trk_z[lo];
                    end else begin
                        lo = hi - 1;
                        span = longint'(trk_t[hi]) - longint'(trk_t[lo]);
                        dt = longint'(c.t) - longint'(trk_t[lo]);
                        frac = (dt <<< 16) / span;
                        r.x = lerp_axis(trk_x[lo], trk_x[hi], frac);
                        r.y = lerp_axis(trk_y[lo], trk_y[hi], frac);
                        r.z = lerp_axis(trk_z[lo], trk_z[hi], frac);
                    end
                end
            end
            OP_CLEAR: trk_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_beat_t mk(logic [1:0] op, logic [31:0] t, logic [31:0] x,
                                     logic [31:0] y, logic [31:0] z);
        cmd_beat_t c;
        c.op = op; c.t = t; c.x = x; c.y = y; c.z = z;
        return c;
    endfunction

    // hold the beat until accepted; random gaps before it unless calm
    task automatic send_cmd(cmd_beat_t c, bit typed, pose_beat_t typed_res);
        pose_beat_t p;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        p = track_step(c);
        if (typed && p !== typed_res) begin
            // a typed row disagreeing with the predictor is a bench bug; count it
            mismatches++;
            $display("directed row inconsistent op=%0d t=%h", c.op, c.t);
        end
        pose_queue.push_back(p);
        s_tdata  <= {6'b0, c};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // result side: random stall bursts, check each accepted beat
    always @(posedge aclk) begin
        pose_beat_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[97:0];
                if (pose_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %h", got);
                end else begin
                    want = pose_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch x %h/%h y %h/%h z %h/%h status %0d/%0d",
                                     want.x, got.x, want.y, got.y, want.z, got.z,
                                     want.status, got.status);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (calm || !aresetn) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("keyframe_track_sampler test failed");
            $finish;
        end
    end

    localparam logic [31:0] SMIN = 32'h8000_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;

    dir_row_t dir_rows[$];

    task automatic add_row(cmd_beat_t c, bit typed, pose_beat_t r);
        dir_row_t d;
        d.cmd = c; d.typed = typed; d.res = r;
        dir_rows.push_back(d);
    endtask

    // random time from a narrow or full range so neighbors and extremes both occur
    function automatic logic [31:0] rnd_time(int mode);
        if (mode == 0) return 32'($signed($urandom_range(0, 200)) - 100) <<< 12;
        return $urandom();
    endfunction

    initial begin
        pose_beat_t zr, er, fr;
        cmd_beat_t c;
        int kind, mode;
        zr = '0;
        er = '0; er.status = ST_EMPTY;
        fr = '0; fr.status = ST_FULL;

        // sample on empty, inserts at the extremes, interior lerp, overwrite, clear
        add_row(mk(OP_SAMPLE, 32'h0, 0, 0, 0), 1, er);
        add_row(mk(OP_NONE, SMAX, SMAX, SMAX, SMAX), 1, zr);
        add_row(mk(OP_INSERT, SMIN, SMIN, SMAX, 32'h0), 1, zr);
        add_row(mk(OP_INSERT, SMAX, SMAX, SMIN, 32'hFFFF_FFFF), 1, zr);
        add_row(mk(OP_SAMPLE, SMIN, 0, 0, 0), 0, zr);
        add_row(mk(OP_SAMPLE, SMAX, 0, 0, 0), 0, zr);
        add_row(mk(OP_SAMPLE, 32'h0, 0, 0, 0), 0, zr);
        add_row(mk(OP_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0), 0, zr);
        add_row(mk(OP_INSERT, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h1234_5678), 1, zr);
        add_row(mk(OP_SAMPLE, 32'h0000_8000, 0, 0, 0), 0, zr);
        add_row(mk(OP_INSERT, 32'h0001_0000, 32'hDEAD_BEEF, 32'h5555_AAAA, 32'hAAAA_5555), 1, zr);
        add_row(mk(OP_SAMPLE, 32'h0001_0000, 0, 0, 0), 0, zr);
        add_row(mk(OP_SAMPLE, 32'h4000_0000, 0, 0, 0), 0, zr);
        add_row(mk(OP_CLEAR, SMAX, SMAX, SMAX, SMAX), 1, zr);
        add_row(mk(OP_SAMPLE, 32'h0001_0000, 0, 0, 0), 1, er);
        add_row(mk(OP_INSERT, 32'h0000_0001, SMAX, SMAX, SMAX), 1, zr);
        add_row(mk(OP_SAMPLE, SMIN, 0, 0, 0), 0, zr);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

        // fill the table to full, hit the full drop and the full overwrite
        send_cmd(mk(OP_CLEAR, 0, 0, 0, 0), 1, zr);
        for (int k = 0; k < MAX_KEYS; k++)
            send_cmd(mk(OP_INSERT, 32'((MAX_KEYS - 1 - k) * 'h1_0000) - 32'h20_0000,
                        $urandom(), $urandom(), $urandom()), 1, zr);
        send_cmd(mk(OP_INSERT, 32'h7000_0000, $urandom(), 0, 0), 1, fr);
        send_cmd(mk(OP_INSERT, 32'hFFE0_0000, $urandom(), $urandom(), $urandom()), 1, zr);
        for (int k = 0; k < 20; k++)
            send_cmd(mk(OP_SAMPLE, rnd_time(k % 2), 0, 0, 0), 0, zr);

        // random part: mostly insert/sample, occasional clear and undefined opcode
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 80) calm = 1'b1;
            kind = $urandom_range(0, 99);
            mode = $urandom_range(0, 3) == 0;
            if (kind < 45)
                c = mk(OP_INSERT, rnd_time(mode), $urandom(), $urandom(), $urandom());
            else if (kind < 94)
                c = mk(OP_SAMPLE, rnd_time(mode), $urandom(), $urandom(), $urandom());
            else if (kind < 97)
                c = mk(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
            else
                c = mk(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom());
            send_cmd(c, 0, zr);
        end
        s_tvalid <= 1'b0;

        while (pose_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("keyframe_track_sampler test passed");
        end else begin
            $display("keyframe_track_sampler test failed");
        end
        $finish;
    end

endmodule
